### rtl/brfee_pkg.sv
// ----------------------------------------------------------------------------
// brfee_pkg
// Shared types and constants of the banked register file with exception
// entry: operation codes, mode codes, entry constants and bank mapping.
// ----------------------------------------------------------------------------
package brfee_pkg;

  typedef enum logic [2:0] {
    FN_READ       = 3'd0,
    FN_WRITE      = 3'd1,
    FN_SET_MODE   = 3'd2,
    FN_UNDEF      = 3'd3,
    FN_ABORT      = 3'd4,
    FN_IRQ        = 3'd5,
    FN_WR_STATUS  = 3'd6,
    FN_WR_SAVED   = 3'd7
  } func_e;

  localparam logic [4:0] MODE_USER = 5'h10;
  localparam logic [4:0] MODE_FIQ  = 5'h11;
  localparam logic [4:0] MODE_IRQ  = 5'h12;
  localparam logic [4:0] MODE_SVC  = 5'h13;
  localparam logic [4:0] MODE_ABT  = 5'h17;
  localparam logic [4:0] MODE_UND  = 5'h1B;
  localparam logic [4:0] MODE_SYS  = 5'h1F;

  localparam logic [31:0] MODE_FIELD = 32'h0000_001F;
  localparam logic [31:0] T_BIT      = 32'h0000_0020;
  localparam int unsigned I_BIT_POS  = 7;

  localparam logic [31:0] ENTER_UND = 32'h0000_009B;
  localparam logic [31:0] ENTER_ABT = 32'h0000_0097;
  localparam logic [31:0] ENTER_IRQ = 32'h0000_0092;

  localparam logic [31:0] VEC_UND = 32'hFFFF_0004;
  localparam logic [31:0] VEC_ABT = 32'hFFFF_0010;
  localparam logic [31:0] VEC_IRQ = 32'hFFFF_0018;

  localparam logic [31:0] STATUS_RESET = 32'h0000_001F;
  localparam logic [31:0] RET_OFFSET   = 32'd4;

  localparam int unsigned USER_DEPTH  = 16;
  localparam int unsigned FIQ_DEPTH   = 7;
  localparam int unsigned PAIR_DEPTH  = 8;
  localparam int unsigned SAVED_DEPTH = 5;

  typedef struct packed {
    logic       vld;
    logic [2:0] idx;
  } slot_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;
  } ctl_cmd_t;

  // r13/r14 pair bank of a mode
  function automatic slot_t pair_slot(input logic [4:0] mode);
    slot_t s;
    s.vld = 1'b1;
    s.idx = 3'd0;
    case (mode)
      MODE_IRQ: s.idx = 3'd0;
      MODE_SVC: s.idx = 3'd1;
      MODE_ABT: s.idx = 3'd2;
      MODE_UND: s.idx = 3'd3;
      default:  s.vld = 1'b0;
    endcase
    return s;
  endfunction

  // saved status slot of a mode
  function automatic slot_t saved_slot(input logic [4:0] mode);
    slot_t s;
    s.vld = 1'b1;
    s.idx = 3'd0;
    case (mode)
      MODE_FIQ: s.idx = 3'd0;
      MODE_IRQ: s.idx = 3'd1;
      MODE_SVC: s.idx = 3'd2;
      MODE_ABT: s.idx = 3'd3;
      MODE_UND: s.idx = 3'd4;
      default:  s.vld = 1'b0;
    endcase
    return s;
  endfunction

endpackage

### rtl/brfee_in_if.sv
// ----------------------------------------------------------------------------
// brfee_in_if
// Request channel of the banked register file: one operation per request.
// ----------------------------------------------------------------------------
interface brfee_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [3:0]  reg_index;
  logic [31:0] write_value;
  logic [4:0]  new_mode;

  modport source (output valid, output func, output reg_index, output write_value,
                  output new_mode, input ready);
  modport sink   (input valid, input func, input reg_index, input write_value,
                  input new_mode, output ready);
endinterface

### rtl/brfee_out_if.sv
// ----------------------------------------------------------------------------
// brfee_out_if
// Result channel of the banked register file: one result per request.
// ----------------------------------------------------------------------------
interface brfee_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic [31:0] status_word;
  logic [31:0] saved_status;
  logic        exception_taken;

  modport source (output valid, output read_value, output status_word,
                  output saved_status, output exception_taken, input ready);
  modport sink   (input valid, input read_value, input status_word,
                  input saved_status, input exception_taken, output ready);
endinterface

### rtl/banked_register_file_exception_entry_unit.sv
// ----------------------------------------------------------------------------
// banked_register_file_exception_entry_unit
// Mode-banked register file with exception entry for an emulated core.
// ----------------------------------------------------------------------------
// Each request reads or writes one register through the current mode's
// banking, switches mode, writes the status or saved status word, or takes
// an undefined, abort or IRQ entry; each produces exactly one result. A
// request executes in the cycle it is accepted and its result appears in
// the result register on the next cycle, so the unit sustains one request
// per cycle; a new request is taken whenever the result register is empty
// or its result is being taken in the same cycle. All banks are flip-flops
// cleared by reset, so no warm-up is needed.
module banked_register_file_exception_entry_unit
  import brfee_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  brfee_in_if.sink    in_i,
  brfee_out_if.source out_o
);

  ctl_cmd_t cmd;

  brfee_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  brfee_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .func_i            (in_i.func),
    .reg_index_i       (in_i.reg_index),
    .write_value_i     (in_i.write_value),
    .new_mode_i        (in_i.new_mode),
    .read_value_o      (out_o.read_value),
    .status_word_o     (out_o.status_word),
    .saved_status_o    (out_o.saved_status),
    .exception_taken_o (out_o.exception_taken)
  );

endmodule

### rtl/brfee_ctrl.sv
// ----------------------------------------------------------------------------
// brfee_ctrl
// Handshake controller: issues one execute command per accepted request and
// tracks whether the result register holds an untaken result.
// ----------------------------------------------------------------------------
module brfee_ctrl
  import brfee_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // A held result that leaves this cycle frees the result register.
  assign in_ready_o = (state_q == ST_EMPTY) || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cmd_o.exec = accept;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_EMPTY: if (accept) state_d = ST_FULL;
      ST_FULL:  if (out_ready_i && !accept) state_d = ST_EMPTY;
      default:  state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_EMPTY;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_o <= (state_d == ST_FULL);
    end
  end

endmodule

### rtl/brfee_dp.sv
// ----------------------------------------------------------------------------
// brfee_dp
// Datapath: register banks, status words, mode register, bank mapping,
// exception entry and the result register.
// ----------------------------------------------------------------------------
module brfee_dp
  import brfee_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_cmd_t    cmd_i,
  input  logic [2:0]  func_i,
  input  logic [3:0]  reg_index_i,
  input  logic [31:0] write_value_i,
  input  logic [4:0]  new_mode_i,
  output logic [31:0] read_value_o,
  output logic [31:0] status_word_o,
  output logic [31:0] saved_status_o,
  output logic        exception_taken_o
);

  logic [31:0] user_q  [USER_DEPTH];
  logic [31:0] user_d  [USER_DEPTH];
  logic [31:0] fiq_q   [FIQ_DEPTH];
  logic [31:0] fiq_d   [FIQ_DEPTH];
  logic [31:0] pair_q  [PAIR_DEPTH];
  logic [31:0] pair_d  [PAIR_DEPTH];
  logic [31:0] saved_q [SAVED_DEPTH];
  logic [31:0] saved_d [SAVED_DEPTH];
  logic [31:0] status_q, status_d;
  logic [4:0]  mode_q, mode_d;

  logic [31:0] rd_d;
  logic        taken_d;
  logic [31:0] pc;
  logic        in_fiq;
  slot_t       cur_pair, cur_saved, new_saved;
  slot_t       ent_pair, ent_saved;
  logic [2:0]  pair_idx;
  logic        ent;
  logic [4:0]  ent_mode;
  logic [31:0] ent_bits, ent_ret, ent_vec;

  assign pc        = user_q[15];
  assign cur_pair  = pair_slot(mode_q);
  assign cur_saved = saved_slot(mode_q);
  assign ent_pair  = pair_slot(ent_mode);
  assign ent_saved = saved_slot(ent_mode);
  // r8-r14 in FIQ mode
  assign in_fiq    = (mode_q == MODE_FIQ) && reg_index_i[3] && (reg_index_i != 4'd15);
  // r13 -> even slot, r14 -> odd slot of the pair
  assign pair_idx  = {cur_pair.idx[1:0], ~reg_index_i[0]};

  always_comb begin
    user_d   = user_q;
    fiq_d    = fiq_q;
    pair_d   = pair_q;
    saved_d  = saved_q;
    status_d = status_q;
    mode_d   = mode_q;
    rd_d     = '0;
    taken_d  = 1'b0;
    ent      = 1'b0;
    ent_mode = MODE_UND;
    ent_bits = ENTER_UND;
    ent_ret  = pc;
    ent_vec  = VEC_UND;

    case (func_e'(func_i))
      FN_READ: begin
        if (in_fiq) rd_d = fiq_q[reg_index_i[2:0]];
        else if (cur_pair.vld && (reg_index_i == 4'd13 || reg_index_i == 4'd14))
          rd_d = pair_q[pair_idx];
        else rd_d = user_q[reg_index_i];
      end
      FN_WRITE: begin
        if (in_fiq) fiq_d[reg_index_i[2:0]] = write_value_i;
        else if (cur_pair.vld && (reg_index_i == 4'd13 || reg_index_i == 4'd14))
          pair_d[pair_idx] = write_value_i;
        else user_d[reg_index_i] = write_value_i;
      end
      FN_SET_MODE: mode_d = new_mode_i;
      FN_UNDEF: ent = 1'b1;
      FN_ABORT: begin
        ent      = 1'b1;
        ent_mode = MODE_ABT;
        ent_bits = ENTER_ABT;
        ent_ret  = pc + RET_OFFSET;
        ent_vec  = VEC_ABT;
      end
      FN_IRQ: begin
        ent      = !status_q[I_BIT_POS];
        ent_mode = MODE_IRQ;
        ent_bits = ENTER_IRQ;
        ent_ret  = pc + RET_OFFSET;
        ent_vec  = VEC_IRQ;
      end
      FN_WR_STATUS: status_d = write_value_i;
      FN_WR_SAVED: if (cur_saved.vld) saved_d[cur_saved.idx] = write_value_i;
      default: ;
    endcase

    // Entry modes always have a pair bank and a saved status.
    if (ent) begin
      pair_d[{ent_pair.idx[1:0], 1'b1}] = ent_ret;
      saved_d[ent_saved.idx]            = status_q;
      status_d = ((status_q & ~MODE_FIELD) | ent_bits) & ~T_BIT;
      mode_d   = ent_mode;
      user_d[15] = ent_vec;
      taken_d  = 1'b1;
    end
  end

  assign new_saved = saved_slot(mode_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < USER_DEPTH; i++)  user_q[i]  <= '0;
      for (int i = 0; i < FIQ_DEPTH; i++)   fiq_q[i]   <= '0;
      for (int i = 0; i < PAIR_DEPTH; i++)  pair_q[i]  <= '0;
      for (int i = 0; i < SAVED_DEPTH; i++) saved_q[i] <= '0;
      status_q <= STATUS_RESET;
      mode_q   <= MODE_SYS;
    end else if (cmd_i.exec) begin
      user_q   <= user_d;
      fiq_q    <= fiq_d;
      pair_q   <= pair_d;
      saved_q  <= saved_d;
      status_q <= status_d;
      mode_q   <= mode_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      read_value_o      <= rd_d;
      status_word_o     <= status_d;
      saved_status_o    <= new_saved.vld ? saved_d[new_saved.idx] : '0;
      exception_taken_o <= taken_d;
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the banked register file and checks each result
// against a cycle-free model of the banks, status and saved status words.
// A directed opening covers the corner cases; random phases with varied
// sender and receiver idling follow, including one long result back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import brfee_pkg::*;

  typedef struct {
    func_e       fn;
    logic [3:0]  rnum;
    logic [31:0] wdata;
    logic [4:0]  mode;
  } reg_op_t;

  typedef struct {
    logic [31:0] rdata;
    logic [31:0] status;
    logic [31:0] saved;
    logic        taken;
  } reg_res_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  brfee_in_if  req_if ();
  brfee_out_if rsp_if ();

  banked_register_file_exception_entry_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model state
  logic [31:0] user_regs [16] = '{default: '0};
  logic [31:0] fiq_regs [7]   = '{default: '0};
  logic [31:0] sp_lr_regs [8] = '{default: '0};
  logic [31:0] spsr_regs [5]  = '{default: '0};
  logic [31:0] cpsr           = STATUS_RESET;
  logic [4:0]  cur_mode       = MODE_SYS;

  reg_op_t  req_q [$];
  reg_res_t expect_q [$];
  reg_op_t  drv_op;
  reg_res_t got;
  reg_res_t want;

  int   err_cnt       = 0;
  int   acc_cnt       = 0;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic stall_hold    = 1'b0;
  logic in_fire       = 1'b0;

  // Base index of the r13/r14 pair, -1 when the mode has none
  function automatic int sp_lr_base(logic [4:0] m);
    case (m)
      MODE_IRQ: return 0;
      MODE_SVC: return 2;
      MODE_ABT: return 4;
      MODE_UND: return 6;
      default:  return -1;
    endcase
  endfunction

  function automatic int spsr_index(logic [4:0] m);
    case (m)
      MODE_FIQ: return 0;
      MODE_IRQ: return 1;
      MODE_SVC: return 2;
      MODE_ABT: return 3;
      MODE_UND: return 4;
      default:  return -1;
    endcase
  endfunction

  function automatic logic [31:0] bank_read(logic [4:0] m, logic [3:0] r);
    int b;
    b = sp_lr_base(m);
    if (m == MODE_FIQ && r >= 8 && r <= 14) return fiq_regs[r - 8];
    if (b >= 0 && r >= 13 && r <= 14) return sp_lr_regs[b + int'(r) - 13];
    return user_regs[r];
  endfunction

  function automatic void bank_write(logic [4:0] m, logic [3:0] r, logic [31:0] v);
    int b;
    b = sp_lr_base(m);
    if (m == MODE_FIQ && r >= 8 && r <= 14) fiq_regs[r - 8] = v;
    else if (b >= 0 && r >= 13 && r <= 14) sp_lr_regs[b + int'(r) - 13] = v;
    else user_regs[r] = v;
  endfunction

  function automatic void take_entry(logic [4:0] m, logic [31:0] bits, logic [31:0] ret,
                                     logic [31:0] vec);
    int s;
    s = spsr_index(m);
    bank_write(m, 4'd14, ret);
    if (s >= 0) spsr_regs[s] = cpsr;
    cpsr = ((cpsr & ~MODE_FIELD) | bits) & ~T_BIT;
    cur_mode = m;
    user_regs[15] = vec;
  endfunction

  function automatic reg_res_t apply_op(reg_op_t op);
    reg_res_t    res;
    logic [31:0] pc;
    int          s;
    res = '{rdata: '0, status: '0, saved: '0, taken: 1'b0};
    pc = user_regs[15];
    case (op.fn)
      FN_READ:     res.rdata = bank_read(cur_mode, op.rnum);
      FN_WRITE:    bank_write(cur_mode, op.rnum, op.wdata);
      FN_SET_MODE: cur_mode = op.mode;
      FN_UNDEF: begin
        take_entry(MODE_UND, ENTER_UND, pc, VEC_UND);
        res.taken = 1'b1;
      end
      FN_ABORT: begin
        take_entry(MODE_ABT, ENTER_ABT, pc + RET_OFFSET, VEC_ABT);
        res.taken = 1'b1;
      end
      FN_IRQ: begin
        if (!cpsr[I_BIT_POS]) begin
          take_entry(MODE_IRQ, ENTER_IRQ, pc + RET_OFFSET, VEC_IRQ);
          res.taken = 1'b1;
        end
      end
      FN_WR_STATUS: cpsr = op.wdata;
      default: begin
        s = spsr_index(cur_mode);
        if (s >= 0) spsr_regs[s] = op.wdata;
      end
    endcase
    s = spsr_index(cur_mode);
    res.status = cpsr;
    res.saved  = (s >= 0) ? spsr_regs[s] : 32'd0;
    return res;
  endfunction

  function automatic void push_req(func_e f, logic [3:0] r, logic [31:0] v, logic [4:0] m);
    reg_op_t op;
    op = '{fn: f, rnum: r, wdata: v, mode: m};
    req_q.push_back(op);
  endfunction

  function automatic logic [4:0] pick_mode();
    int sel;
    sel = $urandom_range(99);
    if (sel < 5) return 5'($urandom_range(31));
    if (sel < 25) return 5'($urandom_range(31, 16));
    case ($urandom_range(6))
      0: return MODE_USER;
      1: return MODE_FIQ;
      2: return MODE_IRQ;
      3: return MODE_SVC;
      4: return MODE_ABT;
      5: return MODE_UND;
      default: return MODE_SYS;
    endcase
  endfunction

  function automatic reg_op_t rand_op();
    reg_op_t op;
    int      sel;
    op.rnum = ($urandom_range(1) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(15, 8));
    case ($urandom_range(9))
      0:       op.wdata = 32'hFFFF_FFFF;
      1:       op.wdata = 32'h0;
      default: op.wdata = $urandom;
    endcase
    op.mode = pick_mode();
    sel = $urandom_range(99);
    if (sel < 28)      op.fn = FN_READ;
    else if (sel < 52) op.fn = FN_WRITE;
    else if (sel < 66) op.fn = FN_SET_MODE;
    else if (sel < 71) op.fn = FN_UNDEF;
    else if (sel < 76) op.fn = FN_ABORT;
    else if (sel < 85) op.fn = FN_IRQ;
    else if (sel < 93) begin
      op.fn = FN_WR_STATUS;
      // keep interrupts unmasked most of the time so IRQ entry happens
      if ($urandom_range(9) < 6) op.wdata[I_BIT_POS] = 1'b0;
    end else op.fn = FN_WR_SAVED;
    return op;
  endfunction

  // Request driver
  always @(negedge clk) begin
    if (rst_ni && (!req_if.valid || in_fire)) begin
      if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_op = req_q.pop_front();
        req_if.func        <= drv_op.fn;
        req_if.reg_index   <= drv_op.rnum;
        req_if.write_value <= drv_op.wdata;
        req_if.new_mode    <= drv_op.mode;
        req_if.valid       <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    rsp_if.ready <= !stall_hold && ($urandom_range(99) >= stall_pct);
  end

  // Monitor and scoreboard
  always @(posedge clk) begin
    if (!rst_ni) begin
      in_fire = 1'b0;
    end else begin
      in_fire = req_if.valid && req_if.ready;
      if (in_fire) begin
        expect_q.push_back(apply_op('{fn: func_e'(req_if.func), rnum: req_if.reg_index,
                                      wdata: req_if.write_value, mode: req_if.new_mode}));
        acc_cnt++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{rdata: rsp_if.read_value, status: rsp_if.status_word,
                saved: rsp_if.saved_status, taken: rsp_if.exception_taken};
        if (expect_q.size() == 0) begin
          $error("result with no request outstanding");
          err_cnt++;
        end else begin
          want = expect_q.pop_front();
          if (got.rdata !== want.rdata) begin
            $error("read_value: expected %h, got %h", want.rdata, got.rdata);
            err_cnt++;
          end
          if (got.status !== want.status) begin
            $error("status_word: expected %h, got %h", want.status, got.status);
            err_cnt++;
          end
          if (got.saved !== want.saved) begin
            $error("saved_status: expected %h, got %h", want.saved, got.saved);
            err_cnt++;
          end
          if (got.taken !== want.taken) begin
            $error("exception_taken: expected %b, got %b", want.taken, got.taken);
            err_cnt++;
          end
        end
      end
    end
  end

  // Long result back-pressure while requests keep coming
  initial begin
    while (acc_cnt < 60) @(posedge clk);
    stall_hold = 1'b1;
    repeat (300) @(posedge clk);
    stall_hold = 1'b0;
  end

  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    req_if.valid       = 1'b0;
    req_if.func        = FN_READ;
    req_if.reg_index   = '0;
    req_if.write_value = '0;
    req_if.new_mode    = MODE_SYS;
    rsp_if.ready       = 1'b0;

    // directed opening
    push_req(FN_READ, 4'd0, 32'h0, MODE_SYS);
    push_req(FN_WRITE, 4'd15, 32'hFFFF_FFFC, MODE_SYS);
    push_req(FN_ABORT, 4'd0, 32'h0, MODE_SYS);              // return address wraps
    push_req(FN_READ, 4'd14, 32'h0, MODE_SYS);
    push_req(FN_READ, 4'd15, 32'h0, MODE_SYS);
    push_req(FN_WR_SAVED, 4'd0, 32'hFFFF_FFFF, MODE_SYS);
    push_req(FN_IRQ, 4'd0, 32'h0, MODE_SYS);                // masked
    push_req(FN_WR_STATUS, 4'd0, 32'h0000_0030, MODE_SYS);  // T set, I clear
    push_req(FN_IRQ, 4'd0, 32'h0, MODE_SYS);
    push_req(FN_WR_STATUS, 4'd0, 32'h0000_001F, MODE_SYS);
    push_req(FN_IRQ, 4'd0, 32'h0, MODE_SYS);                // re-entry from IRQ mode
    push_req(FN_UNDEF, 4'd0, 32'h0, MODE_SYS);
    push_req(FN_SET_MODE, 4'd0, 32'h0, MODE_FIQ);
    push_req(FN_WRITE, 4'd8, 32'hFFFF_FFFF, MODE_SYS);
    push_req(FN_WRITE, 4'd12, 32'hA5A5_A5A5, MODE_SYS);
    push_req(FN_SET_MODE, 4'd0, 32'h0, MODE_USER);
    push_req(FN_READ, 4'd8, 32'h0, MODE_SYS);
    push_req(FN_READ, 4'd12, 32'h0, MODE_SYS);
    push_req(FN_WR_SAVED, 4'd0, 32'h1234_5678, MODE_SYS);   // no saved status here
    push_req(FN_SET_MODE, 4'd0, 32'h0, 5'h05);              // unknown mode code
    push_req(FN_WR_SAVED, 4'd0, 32'h8765_4321, MODE_SYS);
    push_req(FN_READ, 4'd13, 32'h0, MODE_SYS);
    push_req(FN_SET_MODE, 4'd0, 32'h0, MODE_SVC);
    push_req(FN_READ, 4'd13, 32'h0, MODE_SYS);
    push_req(FN_WR_STATUS, 4'd0, 32'hFFFF_FFFF, MODE_SYS);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk);
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 80; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 80; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      for (int n = 0; n < 338; n++) req_q.push_back(rand_op());
      while (req_q.size() != 0) @(negedge clk);
    end

    while (req_q.size() != 0 || req_if.valid || expect_q.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    if (err_cnt == 0 && expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
